// ===== hw/rtl/pfx_pkg.sv =====
// Shared types, constants and codes of the postfix expression evaluator.
package pfx_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_UNDERFLOW = 3'd1,
    ERR_DIVZERO  = 3'd2,
    ERR_INVALID  = 3'd3,
    ERR_OVERFLOW = 3'd4
  } err_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expr;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [2:0]               status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic set_uflow;
    logic rd_next;
    logic cap_rhs;
    logic cap_lhs;
    logic exec;
    logic div_start;
    logic div_cap;
    logic push;
    logic cap_top;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_digit;
    logic is_arith;
    logic is_div;
    logic last;
    logic err_set;
    logic cnt_lt2;
    logic cnt_zero;
    logic rhs_zero;
    logic div_done;
  } dp_sts_t;

endpackage

// ===== hw/rtl/pfx_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module pfx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pfx_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module pfx_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pfx_pkg::DATA_W-1:0] dividend,
  input  logic [pfx_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [pfx_pkg::DATA_W-1:0] quotient
);
  import pfx_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;
  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    quo_r, quo_nxt;
  logic [DATA_W-1:0]    ub_r, ub_nxt;
  logic                 neg_r, neg_nxt;
  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      diff;

  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, ub_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ub_nxt   = ub_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      ub_nxt   = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      neg_nxt  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_nxt = diff[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == DIV_CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    ub_r   <= ub_nxt;
    neg_r  <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

// ===== hw/rtl/pfx_dp.sv =====
// Datapath: operand stack, count, error latch, ALU, divider and result register.
module pfx_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  pfx_pkg::in_item_t   in_data,
  input  pfx_pkg::dp_cmd_t    cmd,
  output pfx_pkg::dp_sts_t    sts,
  output pfx_pkg::out_item_t  out_data
);
  import pfx_pkg::*;

  logic [7:0]        sym_r, sym_nxt;
  logic              last_r, last_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  err_t              err_r, err_nxt;
  logic [DATA_W-1:0] rhs_r, rhs_nxt;
  logic [DATA_W-1:0] lhs_r, lhs_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  out_item_t         out_r, out_nxt;

  logic [7:0]        sym_cur;
  logic [7:0]        digit;
  logic              is_digit, is_add, is_sub, is_mul, is_div;
  logic              full;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  logic [ADDR_W-1:0] raddr;
  logic [DATA_W-1:0] rdata;
  logic              we;
  logic              div_done;
  logic [DATA_W-1:0] div_q;
  logic [DATA_W-1:0] alu;

  assign sym_cur  = cmd.load_in ? in_data.symbol : sym_r;
  assign digit    = sym_cur - CH_ZERO;
  assign is_digit = sym_cur inside {[CH_ZERO:CH_NINE]};
  assign is_add   = sym_cur == CH_PLUS;
  assign is_sub   = sym_cur == CH_MINUS;
  assign is_mul   = sym_cur == CH_STAR;
  assign is_div   = sym_cur == CH_SLASH;

  assign full   = cnt_r >= CNT_W'(STACK_DEPTH);
  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign cnt_m2 = cnt_r - CNT_W'(2);
  assign raddr  = cmd.rd_next ? cnt_m2[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];
  assign we     = cmd.push && !full;

  pfx_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (res_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  pfx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (lhs_r),
    .divisor  (rhs_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    alu = lhs_r * rhs_r;
    if (is_add) begin
      alu = lhs_r + rhs_r;
    end else if (is_sub) begin
      alu = lhs_r - rhs_r;
    end
  end

  always_comb begin
    sym_nxt  = sym_r;
    last_nxt = last_r;
    cnt_nxt  = cnt_r;
    err_nxt  = err_r;
    rhs_nxt  = cmd.cap_rhs ? rdata : rhs_r;
    lhs_nxt  = cmd.cap_lhs ? rdata : lhs_r;
    res_nxt  = res_r;
    out_nxt  = out_r;
    if (cmd.load_in) begin
      sym_nxt  = in_data.symbol;
      last_nxt = in_data.end_of_expr;
      res_nxt  = DATA_W'(digit);
    end
    if (cmd.set_uflow && err_r == ERR_NONE) begin
      err_nxt = ERR_UNDERFLOW;
    end
    if (cmd.cap_lhs) begin
      cnt_nxt = cnt_m2;
    end
    if (cmd.exec && err_r == ERR_NONE) begin
      if (is_add || is_sub || is_mul) begin
        res_nxt = alu;
      end else if (is_div) begin
        if (rhs_r == '0) begin
          err_nxt = ERR_DIVZERO;
        end
      end else begin
        err_nxt = ERR_INVALID;
      end
    end
    if (cmd.div_cap) begin
      res_nxt = div_q;
    end
    if (cmd.cap_top) begin
      res_nxt = rdata;
    end
    if (cmd.push) begin
      if (full) begin
        if (err_r == ERR_NONE) begin
          err_nxt = ERR_OVERFLOW;
        end
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    if (cmd.emit) begin
      out_nxt.value  = (err_r == ERR_NONE) ? res_r : '0;
      out_nxt.status = err_r;
      cnt_nxt        = '0;
      err_nxt        = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      err_r <= ERR_NONE;
    end else begin
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r  <= sym_nxt;
    last_r <= last_nxt;
    rhs_r  <= rhs_nxt;
    lhs_r  <= lhs_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign sts.is_digit = is_digit;
  assign sts.is_arith = is_add || is_sub || is_mul;
  assign sts.is_div   = is_div;
  assign sts.last     = cmd.load_in ? in_data.end_of_expr : last_r;
  assign sts.err_set  = err_r != ERR_NONE;
  assign sts.cnt_lt2  = cnt_r < CNT_W'(2);
  assign sts.cnt_zero = cnt_r == '0;
  assign sts.rhs_zero = rhs_r == '0;
  assign sts.div_done = div_done;

  assign out_data = out_r;

`ifndef NO_ASSERTIONS
  // The count never passes the stack depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // Giving a result leaves an empty stack and a clear error latch.
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (cnt_r == '0 && err_r == ERR_NONE))
    else $error("result given without clearing state");

  // The divider is never started on a zero divisor.
  a_no_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> rhs_r != '0)
    else $error("divider started with zero divisor");
`endif

endmodule

// ===== hw/rtl/pfx_ctrl.sv =====
// Controller state machine that sequences each symbol through the datapath.
module pfx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pfx_pkg::dp_sts_t  sts,
  output pfx_pkg::dp_cmd_t  cmd
);
  import pfx_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_RD_R = 10'b00_0000_0010,
    S_RD_L = 10'b00_0000_0100,
    S_LHS  = 10'b00_0000_1000,
    S_EXEC = 10'b00_0001_0000,
    S_DIV  = 10'b00_0010_0000,
    S_PUSH = 10'b00_0100_0000,
    S_END  = 10'b00_1000_0000,
    S_FIN  = 10'b01_0000_0000,
    S_EMIT = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  state_t after_sym;

  assign out_free  = !out_valid_r || !out_stall;
  assign after_sym = sts.last ? S_END : S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (sts.err_set) begin
            state_nxt = after_sym;
          end else if (sts.is_digit) begin
            state_nxt = S_PUSH;
          end else if (sts.cnt_lt2) begin
            cmd.set_uflow = 1'b1;
            state_nxt     = after_sym;
          end else begin
            state_nxt = S_RD_R;
          end
        end
      end
      S_RD_R: begin
        state_nxt = S_RD_L;
      end
      S_RD_L: begin
        cmd.cap_rhs = 1'b1;
        cmd.rd_next = 1'b1;
        state_nxt   = S_LHS;
      end
      S_LHS: begin
        cmd.cap_lhs = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_arith) begin
          state_nxt = S_PUSH;
        end else if (sts.is_div && !sts.rhs_zero) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = after_sym;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          state_nxt   = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = after_sym;
      end
      S_END: begin
        if (!sts.err_set && sts.cnt_zero) begin
          cmd.set_uflow = 1'b1;
          state_nxt     = S_EMIT;
        end else if (!sts.err_set) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_FIN: begin
        cmd.cap_top = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  // A started division waits in the divide state until the quotient is back.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !sts.div_done) |=> state_r == S_DIV)
    else $error("left divide state early");

  // A result is only loaded when the output register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result overwrote a waiting result");

  // The end of an expression with an error latched goes to the result state.
  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_END && sts.err_set) |=> state_r == S_EMIT)
    else $error("end of expression did not give a result");
`endif

endmodule

// ===== hw/rtl/postfix_expression_evaluator_core.sv =====
// Top level of the postfix expression evaluator: controller plus datapath.
//
//   channel   direction  handshake           payload
//   in_       input      in_valid/in_stall   in_data  (symbol, end_of_expr)
//   out_      output     out_valid/out_stall out_data (value, status)
//
// A digit goes straight to the push step; +, - and * first pass the two
// registered stack reads and the ALU register; / also waits for the
// one-bit-per-cycle divider. A zero divisor or an invalid character stops
// after the ALU step, and a request met with an error latched or too few
// entries is settled as it is taken in. A request marked as the end adds
// the final stack read and the result register, and waits until it is taken.
// Reset (rst_n low, synchronous) empties the stack and clears the error
// latch; the stack memory itself needs no clearing pass.
// A stalled result waits in the output register while the next request is
// still taken in.
module postfix_expression_evaluator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pfx_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pfx_pkg::out_item_t  out_data
);
  import pfx_pkg::*;

  // Command and status buses between the sequencer and the datapath.
  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller decides, per request, which stack reads, ALU work,
  // push and result steps happen.
  pfx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the stack, the error latch and the result register.
  pfx_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== tb/postfix_expression_evaluator_core_checker.sv =====
// Checker for the postfix evaluator: predicts results from accepted requests and compares.
module postfix_expression_evaluator_core_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  pfx_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  pfx_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import pfx_pkg::*;

  logic [DATA_W-1:0] eval_stack [STACK_DEPTH];
  int                eval_depth;
  err_t              eval_err;
  out_item_t         result_q [$];

  assign pending_count = result_q.size();

  function automatic logic [DATA_W-1:0] quot_trunc(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] ua, ub, q;
    ua = a[DATA_W-1] ? -a : a;
    ub = b[DATA_W-1] ? -b : b;
    q  = ua / ub;
    return (a[DATA_W-1] != b[DATA_W-1]) ? -q : q;
  endfunction

  task automatic note_err(err_t code);
    if (eval_err == ERR_NONE) eval_err = code;
  endtask

  task automatic push_val(logic [DATA_W-1:0] v);
    if (eval_depth >= STACK_DEPTH) begin
      note_err(ERR_OVERFLOW);
    end else begin
      eval_stack[eval_depth] = v;
      eval_depth++;
    end
  endtask

  task automatic pop_val(output logic [DATA_W-1:0] v);
    v = '0;
    if (eval_depth == 0) begin
      note_err(ERR_UNDERFLOW);
    end else begin
      eval_depth--;
      v = eval_stack[eval_depth];
    end
  endtask

  task automatic apply_symbol(in_item_t req);
    logic [DATA_W-1:0] rhs, lhs, top;
    out_item_t         res;
    if (eval_err == ERR_NONE) begin
      if (req.symbol >= CH_ZERO && req.symbol <= CH_NINE) begin
        push_val(DATA_W'(req.symbol - CH_ZERO));
      end else begin
        pop_val(rhs);
        pop_val(lhs);
        if (eval_err == ERR_NONE) begin
          case (req.symbol)
            CH_PLUS:  push_val(lhs + rhs);
            CH_MINUS: push_val(lhs - rhs);
            CH_STAR:  push_val(lhs * rhs);
            CH_SLASH: begin
              if (rhs == '0) note_err(ERR_DIVZERO);
              else push_val(quot_trunc(lhs, rhs));
            end
            default:  note_err(ERR_INVALID);
          endcase
        end
      end
    end
    if (req.end_of_expr) begin
      top = '0;
      if (eval_err == ERR_NONE) pop_val(top);
      res.value  = (eval_err == ERR_NONE) ? top : '0;
      res.status = eval_err;
      result_q.push_back(res);
      eval_depth = 0;
      eval_err   = ERR_NONE;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      eval_depth = 0;
      eval_err   = ERR_NONE;
      result_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) apply_symbol(in_data);
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result value=%0d status=%0d", $time,
                   out_data.value, out_data.status);
        end else begin
          want = result_q.pop_front();
          if (out_data.value !== want.value || out_data.status !== want.status) begin
            fail_count++;
            $display("%0t: mismatch expected value=%0d status=%0d, actual value=%0d status=%0d",
                     $time, want.value, want.status, out_data.value, out_data.status);
          end
        end
      end
    end
  end

endmodule

// ===== tb/postfix_expression_evaluator_core_tb.sv =====
// Testbench top for the postfix evaluator: stimulus, stall patterns and verdict.
module postfix_expression_evaluator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfx_pkg::*;

  localparam int RANDOM_REQS = 1460;
  localparam int WATCH_LIMIT = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        pending_count;
  int        idle_cycles;
  bit        quiet_phase;
  bit        hold_off_req;

  postfix_expression_evaluator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  postfix_expression_evaluator_core_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sends one request; the payload holds until the block takes it. An
  // optional random idle burst comes first, outside the quiet phase. Valid
  // stays up after the accepting edge; an idle burst in the next call or the
  // end of the stimulus drops it.
  task automatic send_req(logic [7:0] sym, logic last);
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{symbol: sym, end_of_expr: last};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // A random character from the whole byte range, weighted toward digits
  // and operators so that most expressions get far into evaluation.
  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CH_ZERO + 8'($urandom_range(0, 9));
      4:          return CH_PLUS;
      5:          return CH_MINUS;
      6:          return CH_STAR;
      7:          return CH_SLASH;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Builds a well-formed expression: n digits with n-1 operators
  // mixed in so that the stack never runs short.
  task automatic send_valid_expr(int n_digits);
    int held, digits_left;
    logic [7:0] op;
    held = 0;
    digits_left = n_digits;
    while (digits_left > 0 || held > 1) begin
      if (digits_left > 0 && (held < 2 || $urandom_range(0, 1) == 0)) begin
        send_req(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        held++;
        digits_left--;
      end else begin
        case ($urandom_range(0, 3))
          0: op = CH_PLUS;
          1: op = CH_MINUS;
          2: op = CH_STAR;
          default: op = CH_SLASH;
        endcase
        send_req(op, 1'b0);
        held--;
      end
    end
    // The final character carries the end mark: one more digit is pushed
    // and a last operator combines it with what the stack holds.
    if (held >= 1 && $urandom_range(0, 1) == 0) begin
      send_req(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      send_req(CH_PLUS, 1'b1);
    end else begin
      send_req(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      send_req(CH_STAR, 1'b1);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off on request, and a
  // steady ready state in the final part of the run.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("** postfix_expression_evaluator_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int k;
    in_valid     = 1'b0;
    in_data      = '0;
    rst_n        = 1'b0;
    quiet_phase  = 1'b0;
    hold_off_req = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: each operator, truncating and wrapping division,
    // each error kind, and the extremes of the symbol byte.
    send_req("7", 1'b0); send_req("2", 1'b0); send_req(CH_PLUS, 1'b1);
    send_req("3", 1'b0); send_req("9", 1'b0); send_req(CH_MINUS, 1'b1);
    send_req("9", 1'b0); send_req("9", 1'b0); send_req(CH_STAR, 1'b1);
    send_req("7", 1'b0); send_req("2", 1'b0); send_req(CH_SLASH, 1'b1);
    send_req("0", 1'b0); send_req("7", 1'b0); send_req(CH_MINUS, 1'b0);
    send_req("2", 1'b0); send_req(CH_SLASH, 1'b1);          // -7/2 truncates to -3
    send_req("5", 1'b0); send_req("0", 1'b0); send_req(CH_SLASH, 1'b1);  // divide by zero
    send_req("4", 1'b1);                                     // lone digit
    send_req(CH_PLUS, 1'b1);                                 // underflow on operator
    send_req(8'h00, 1'b1);                                   // NUL with empty stack
    send_req("1", 1'b0); send_req("2", 1'b0); send_req(8'h00, 1'b1); // invalid character
    send_req("1", 1'b0); send_req("2", 1'b0); send_req(8'hFF, 1'b0);
    send_req("3", 1'b1);                                     // ignored after error
    send_req("8", 1'b0); send_req("6", 1'b1);                // leftover entry dropped

    // Most negative value over minus one: 2 * 64^5 is 2^31, which wraps
    // to the most negative value.
    send_req("2", 1'b0);
    for (k = 0; k < 5; k++) begin
      send_req("8", 1'b0); send_req("8", 1'b0);
      send_req(CH_STAR, 1'b0); send_req(CH_STAR, 1'b0);
    end
    send_req("0", 1'b0); send_req("1", 1'b0); send_req(CH_MINUS, 1'b0);
    send_req(CH_SLASH, 1'b1);

    // Overflow: more digits than the stack holds.
    for (k = 0; k <= STACK_DEPTH; k++) send_req(CH_ZERO + 8'(k % 10), 1'b0);
    send_req("1", 1'b1);
    // A full stack that still ends cleanly.
    for (k = 0; k < STACK_DEPTH; k++) send_req("9", 1'b0);
    send_req(CH_PLUS, 1'b1);

    // Random part: mostly well-formed expressions, the rest noise.
    sent = 0;
    while (sent < RANDOM_REQS) begin
      if (sent > RANDOM_REQS / 3 && sent < RANDOM_REQS / 3 + 40 && !hold_off_req)
        hold_off_req = 1'b1;
      if (sent > RANDOM_REQS * 4 / 5) quiet_phase = 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        k = $urandom_range(1, 12);
        send_valid_expr(k);
        sent += 2 * k + 1;
      end else begin
        k = $urandom_range(1, 8);
        repeat (k) send_req(pick_symbol(), $urandom_range(0, 5) == 0);
        send_req(pick_symbol(), 1'b1);
        sent += k + 1;
      end
    end
    in_valid <= 1'b0;

    k = 0;
    while (pending_count != 0 && k < WATCH_LIMIT) begin
      @(negedge clk);
      k++;
    end
    repeat (50) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("** postfix_expression_evaluator_core: PASSED **");
    end else begin
      $display("** postfix_expression_evaluator_core: FAILED **");
    end
    $finish;
  end
endmodule
